// ===== rtl/ctlx_pkg.sv =====
package ctlx_pkg;

    localparam int CoeffFracBitsDef = 16;

    // Quotient n has 32 bits, Horner accumulators carry magnitude up to 2^40.
    localparam int QW   = 32;
    localparam int AccW = 42;

    localparam logic [40:0] HornerBound = 41'h100_0000_0000;

    localparam logic [8:0]             PolyLead = 9'd449;
    localparam logic signed [AccW-1:0] KPoly1   = 42'sd231014400;
    localparam logic signed [AccW-1:0] KPoly2   = 42'sd447171789;
    localparam logic signed [AccW-1:0] KPoly3   = 42'sd361780347;

    typedef enum logic [1:0] {
        StOk      = 2'd0,
        StZero    = 2'd1,
        StDenZero = 2'd2,
        StClamp   = 2'd3
    } cct_status_t;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] temperature_kelvin;
        logic [15:0] illuminance;
        logic [1:0]  cct_status;
        logic        lux_clamped;
    } out_beat_t;

    // Per-item flags that ride alongside the arithmetic pipeline.
    typedef struct packed {
        logic [15:0] lux;
        logic        luxc;
        logic        zero;
        logic        dz;
    } side_t;

    // Coefficient m / 100000 rounded half away from zero to f fraction bits, for non-negative m.
    function automatic longint cq(input int m, input int f);
        return ((longint'(m) <<< f) + 64'sd50000) / 64'sd100000;
    endfunction

endpackage

// ===== rtl/rgb_color_temperature_and_lux.sv =====
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while a result beat waits on m_ready, so s_ready = !m_valid || m_ready.
// The depth is set by the 32-stage restoring divider that forms n.
// Reset (aresetn low, synchronous) clears every valid bit; data registers are not reset.
module rgb_color_temperature_and_lux #(
    parameter int COEFF_FRAC_BITS = ctlx_pkg::CoeffFracBitsDef
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ctlx_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ctlx_pkg::out_beat_t m_data
);
    import ctlx_pkg::*;

    localparam int DW = COEFF_FRAC_BITS + 21;

    logic          en;
    logic          mtx_v, div_v;
    logic [DW-1:0] rem_w, den_w;
    logic [15:0]   nbits_w;
    logic          neg_w, ovf_w, dneg_w, dovf_w;
    side_t         mside_w, dside_w;
    logic [QW-1:0] q_w;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    ctlx_mtx #(.F(COEFF_FRAC_BITS)) u_mtx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (mtx_v),
        .rem_o     (rem_w),
        .den_o     (den_w),
        .nbits_o   (nbits_w),
        .neg_o     (neg_w),
        .ovf_o     (ovf_w),
        .side_o    (mside_w)
    );

    ctlx_div #(.F(COEFF_FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mtx_v),
        .rem_i     (rem_w),
        .den_i     (den_w),
        .nbits_i   (nbits_w),
        .neg_i     (neg_w),
        .ovf_i     (ovf_w),
        .side_i    (mside_w),
        .out_valid (div_v),
        .q_o       (q_w),
        .neg_o     (dneg_w),
        .ovf_o     (dovf_w),
        .side_o    (dside_w)
    );

    ctlx_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (div_v),
        .q_i       (q_w),
        .neg_i     (dneg_w),
        .ovf_i     (dovf_w),
        .side_i    (dside_w),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

endmodule

// ===== rtl/ctlx_mtx.sv =====
module ctlx_mtx #(
    parameter int F = ctlx_pkg::CoeffFracBitsDef
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  ctlx_pkg::in_beat_t in_data,
    output logic               out_valid,
    output logic [F+20:0]      rem_o,
    output logic [F+20:0]      den_o,
    output logic [15:0]        nbits_o,
    output logic               neg_o,
    output logic               ovf_o,
    output ctlx_pkg::side_t    side_o
);
    import ctlx_pkg::*;

    localparam int CW  = F + 2;
    localparam int TW  = F + 19;
    localparam int SW  = F + 20;
    localparam int MW  = F + 19;
    localparam int SH  = 22;
    localparam int HW  = MW - SH;
    localparam int PLW = F + SH;
    localparam int PHW = F + HW;
    localparam int NW  = F + 22;
    localparam int DW  = F + 21;

    localparam logic signed [CW-1:0] KX [9] = '{
        CW'(-cq(14282, F)), CW'(cq(154924, F)), CW'(-cq(95641, F)),
        CW'(-cq(32466, F)), CW'(cq(157837, F)), CW'(-cq(73191, F)),
        CW'(-cq(68202, F)), CW'(cq(77073, F)),  CW'(cq(56332, F))
    };
    localparam logic [F-1:0] K332  = F'(cq(33200, F));
    localparam logic [F-1:0] K1858 = F'(cq(18580, F));

    logic [15:0] ch [3];
    assign ch[0] = in_data.red;
    assign ch[1] = in_data.green;
    assign ch[2] = in_data.blue;

    // Stage 1: color matrix.
    logic signed [TW-1:0] t_next [3];
    logic signed [TW-1:0] t_reg  [3];
    logic                 zero1_reg;
    logic                 v1_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_next[i] = '0;
            for (int j = 0; j < 3; j++) begin
                t_next[i] = t_next[i] + TW'(KX[3*i+j]) * signed'(TW'(ch[j]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg     <= t_next;
            zero1_reg <= (ch[0] == 16'd0) && (ch[1] == 16'd0) && (ch[2] == 16'd0);
        end
    end

    // Stage 2: sum of tristimulus values, lux from Y.
    logic signed [SW-1:0] s_next;
    logic [TW-1:0]        y_mag;
    logic [TW-1:0]        y_cnt;
    side_t                side2_next;
    logic signed [SW-1:0] s2_reg;
    logic signed [TW-1:0] t0_2_reg, t1_2_reg;
    side_t                side2_reg;
    logic                 v2_reg;

    always_comb begin
        s_next = SW'(t_reg[0]) + SW'(t_reg[1]) + SW'(t_reg[2]);
        y_mag  = t_reg[1][TW-1] ? TW'(-t_reg[1]) : TW'(t_reg[1]);
        y_cnt  = y_mag >> F;
        side2_next      = '0;
        side2_next.zero = zero1_reg;
        if (t_reg[1][TW-1]) begin
            side2_next.luxc = (y_cnt != '0);
        end else if (y_cnt > TW'(16'hFFFF)) begin
            side2_next.lux  = 16'hFFFF;
            side2_next.luxc = 1'b1;
        end else begin
            side2_next.lux = y_cnt[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_reg    <= s_next;
            t0_2_reg  <= t_reg[0];
            t1_2_reg  <= t_reg[1];
            side2_reg <= side2_next;
        end
    end

    // Stage 3: partial products of |S| with the two scale constants.
    logic [MW-1:0]        s_mag;
    logic [PLW-1:0]       p332l_reg, p1858l_reg;
    logic [PHW-1:0]       p332h_reg, p1858h_reg;
    logic                 sneg3_reg;
    logic signed [TW-1:0] t0_3_reg, t1_3_reg;
    side_t                side3_reg;
    logic                 v3_reg;

    assign s_mag = s2_reg[SW-1] ? MW'(-s2_reg) : MW'(s2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p332l_reg  <= PLW'(K332) * PLW'(s_mag[SH-1:0]);
            p332h_reg  <= PHW'(K332) * PHW'(s_mag[MW-1:SH]);
            p1858l_reg <= PLW'(K1858) * PLW'(s_mag[SH-1:0]);
            p1858h_reg <= PHW'(K1858) * PHW'(s_mag[MW-1:SH]);
            sneg3_reg  <= s2_reg[SW-1];
            t0_3_reg   <= t0_2_reg;
            t1_3_reg   <= t1_2_reg;
            side3_reg  <= side2_reg;
        end
    end

    // Stage 4: numerator and denominator of n.
    logic [F+MW-1:0]      sum332, sum1858;
    logic signed [NW-1:0] sc332, sc1858;
    logic signed [NW-1:0] num_next, den_next;
    logic signed [NW-1:0] num4_reg, den4_reg;
    side_t                side4_reg;
    logic                 v4_reg;

    always_comb begin
        sum332  = {p332h_reg, SH'(0)} + (F+MW)'(p332l_reg);
        sum1858 = {p1858h_reg, SH'(0)} + (F+MW)'(p1858l_reg);
        sc332   = signed'(NW'(sum332 >> F));
        sc1858  = signed'(NW'(sum1858 >> F));
        if (sneg3_reg) begin
            sc332  = -sc332;
            sc1858 = -sc1858;
        end
        num_next = NW'(t0_3_reg) - sc332;
        den_next = sc1858 - NW'(t1_3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg  <= num_next;
            den4_reg  <= den_next;
            side4_reg <= side3_reg;
        end
    end

    // Stage 5: magnitudes, overflow check and divider setup.
    logic [DW-1:0] num_mag, den_mag;
    side_t         side5_next;
    logic          v5_reg;

    always_comb begin
        num_mag       = num4_reg[NW-1] ? DW'(-num4_reg) : DW'(num4_reg);
        den_mag       = den4_reg[NW-1] ? DW'(-den4_reg) : DW'(den4_reg);
        side5_next    = side4_reg;
        side5_next.dz = (den_mag == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    // A quotient of 2^32 or more saturates, so it is flagged here.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_o   <= num_mag >> 16;
            den_o   <= den_mag;
            nbits_o <= num_mag[15:0];
            neg_o   <= num4_reg[NW-1] ^ den4_reg[NW-1];
            ovf_o   <= (DW+16)'(num_mag) >= {den_mag, 16'd0};
            side_o  <= side5_next;
        end
    end

    assign out_valid = v5_reg;

endmodule

// ===== rtl/ctlx_div.sv =====
module ctlx_div #(
    parameter int F = ctlx_pkg::CoeffFracBitsDef
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [F+20:0]          rem_i,
    input  logic [F+20:0]          den_i,
    input  logic [15:0]            nbits_i,
    input  logic                   neg_i,
    input  logic                   ovf_i,
    input  ctlx_pkg::side_t        side_i,
    output logic                   out_valid,
    output logic [ctlx_pkg::QW-1:0] q_o,
    output logic                   neg_o,
    output logic                   ovf_o,
    output ctlx_pkg::side_t        side_o
);
    import ctlx_pkg::*;

    localparam int DW = F + 21;

    logic [DW-1:0] rem_w  [QW+1];
    logic [DW-1:0] den_w  [QW+1];
    logic [15:0]   nb_w   [QW+1];
    logic [QW-1:0] q_w    [QW+1];
    logic          neg_w  [QW+1];
    logic          ovf_w  [QW+1];
    side_t         side_w [QW+1];
    logic          v_w    [QW+1];

    assign rem_w[0]  = rem_i;
    assign den_w[0]  = den_i;
    assign nb_w[0]   = nbits_i;
    assign q_w[0]    = '0;
    assign neg_w[0]  = neg_i;
    assign ovf_w[0]  = ovf_i;
    assign side_w[0] = side_i;
    assign v_w[0]    = in_valid;

    // One restoring step per stage; the low 16 dividend bits are zero.
    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW:0]   cand;
        logic          fits;
        logic [DW-1:0] rem_next;
        logic [DW-1:0] rem_reg, den_reg;
        logic [15:0]   nb_reg;
        logic [QW-1:0] q_reg;
        logic          neg_reg, ovf_reg, v_reg;
        side_t         side_reg;

        always_comb begin
            cand     = {rem_w[k], nb_w[k][15]};
            fits     = cand >= {1'b0, den_w[k]};
            rem_next = fits ? DW'(cand - {1'b0, den_w[k]}) : DW'(cand);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= rem_next;
                den_reg  <= den_w[k];
                nb_reg   <= {nb_w[k][14:0], 1'b0};
                q_reg    <= {q_w[k][QW-2:0], fits};
                neg_reg  <= neg_w[k];
                ovf_reg  <= ovf_w[k];
                side_reg <= side_w[k];
            end
        end

        assign rem_w[k+1]  = rem_reg;
        assign den_w[k+1]  = den_reg;
        assign nb_w[k+1]   = nb_reg;
        assign q_w[k+1]    = q_reg;
        assign neg_w[k+1]  = neg_reg;
        assign ovf_w[k+1]  = ovf_reg;
        assign side_w[k+1] = side_reg;
        assign v_w[k+1]    = v_reg;
    end

    assign out_valid = v_w[QW];
    assign q_o       = q_w[QW];
    assign neg_o     = neg_w[QW];
    assign ovf_o     = ovf_w[QW];
    assign side_o    = side_w[QW];

endmodule

// ===== rtl/ctlx_hstep.sv =====
module ctlx_hstep #(
    parameter logic signed [ctlx_pkg::AccW-1:0] K = ctlx_pkg::KPoly2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [ctlx_pkg::AccW-1:0] acc_i,
    input  logic [ctlx_pkg::QW-1:0]        mn_i,
    input  logic                           nneg_i,
    input  ctlx_pkg::side_t                side_i,
    output logic                           out_valid,
    output logic signed [ctlx_pkg::AccW-1:0] acc_o,
    output logic [ctlx_pkg::QW-1:0]        mn_o,
    output logic                           nneg_o,
    output ctlx_pkg::side_t                side_o
);
    import ctlx_pkg::*;

    localparam logic signed [AccW-1:0] HbPos = signed'(AccW'(HornerBound));

    // Stage 1: |acc| * |n| as two partial products.
    logic [40:0]   acc_mag;
    logic [55:0]   pl_reg;
    logic [48:0]   ph_reg;
    logic          sgn1_reg;
    logic [QW-1:0] mn1_reg;
    logic          nneg1_reg;
    side_t         side1_reg;
    logic          v1_reg;

    assign acc_mag = acc_i[AccW-1] ? 41'(-acc_i) : 41'(acc_i);

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg    <= 56'(acc_mag[23:0]) * 56'(mn_i);
            ph_reg    <= 49'(acc_mag[40:24]) * 49'(mn_i);
            sgn1_reg  <= acc_i[AccW-1] ^ nneg_i;
            mn1_reg   <= mn_i;
            nneg1_reg <= nneg_i;
            side1_reg <= side_i;
        end
    end

    // Stage 2: recombine, drop 16 fraction bits, saturate the magnitude.
    logic [72:0]   full;
    logic [40:0]   p_next;
    logic [40:0]   p2_reg;
    logic          sgn2_reg;
    logic [QW-1:0] mn2_reg;
    logic          nneg2_reg;
    side_t         side2_reg;
    logic          v2_reg;

    always_comb begin
        full   = {ph_reg, 24'd0} + 73'(pl_reg);
        p_next = (full[72:16] > 57'(HornerBound)) ? HornerBound : full[56:16];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_reg    <= p_next;
            sgn2_reg  <= sgn1_reg;
            mn2_reg   <= mn1_reg;
            nneg2_reg <= nneg1_reg;
            side2_reg <= side1_reg;
        end
    end

    // Stage 3: add the next coefficient and clamp.
    logic signed [AccW-1:0] sp;
    logic signed [AccW-1:0] sum;
    logic signed [AccW-1:0] acc_next;
    logic                   v3_reg;

    always_comb begin
        sp  = signed'(AccW'(p2_reg));
        sum = (sgn2_reg ? -sp : sp) + K;
        if (sum > HbPos) begin
            acc_next = HbPos;
        end else if (sum < -HbPos) begin
            acc_next = -HbPos;
        end else begin
            acc_next = sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_o  <= acc_next;
            mn_o   <= mn2_reg;
            nneg_o <= nneg2_reg;
            side_o <= side2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;

endmodule

// ===== rtl/ctlx_poly.sv =====
module ctlx_poly (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [ctlx_pkg::QW-1:0] q_i,
    input  logic                    neg_i,
    input  logic                    ovf_i,
    input  ctlx_pkg::side_t         side_i,
    output logic                    out_valid,
    output ctlx_pkg::out_beat_t     out_data
);
    import ctlx_pkg::*;

    localparam logic [QW-1:0] NegLimit = {1'b1, (QW-1)'(0)};
    localparam logic [QW-1:0] PosLimit = {1'b0, {(QW-1){1'b1}}};

    // Stage 1: saturate n to signed Q16.16.
    logic [QW-1:0] mn_next;
    logic [QW-1:0] mn1_reg;
    logic          nneg1_reg;
    side_t         side1_reg;
    logic          v1_reg;

    always_comb begin
        if (neg_i) begin
            mn_next = (ovf_i || q_i > NegLimit) ? NegLimit : q_i;
        end else begin
            mn_next = (ovf_i || q_i > PosLimit) ? PosLimit : q_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mn1_reg   <= mn_next;
            nneg1_reg <= neg_i;
            side1_reg <= side_i;
        end
    end

    // Stage 2: first Horner step; the lead coefficient is an integer, so it never saturates.
    logic [40:0]            lead;
    logic signed [AccW-1:0] slead;
    logic signed [AccW-1:0] acc2_reg;
    logic [QW-1:0]          mn2_reg;
    logic                   nneg2_reg;
    side_t                  side2_reg;
    logic                   v2_reg;

    always_comb begin
        lead  = 41'(mn1_reg) * 41'(PolyLead);
        slead = signed'(AccW'(lead));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc2_reg  <= (nneg1_reg ? -slead : slead) + KPoly1;
            mn2_reg   <= mn1_reg;
            nneg2_reg <= nneg1_reg;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    logic                   va_w, vb_w;
    logic signed [AccW-1:0] acca_w, accb_w;
    logic [QW-1:0]          mna_w, mnb_w;
    logic                   nnega_w, nnegb_w;
    side_t                  sidea_w, sideb_w;

    ctlx_hstep #(.K(KPoly2)) u_step2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .acc_i     (acc2_reg),
        .mn_i      (mn2_reg),
        .nneg_i    (nneg2_reg),
        .side_i    (side2_reg),
        .out_valid (va_w),
        .acc_o     (acca_w),
        .mn_o      (mna_w),
        .nneg_o    (nnega_w),
        .side_o    (sidea_w)
    );

    ctlx_hstep #(.K(KPoly3)) u_step3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (va_w),
        .acc_i     (acca_w),
        .mn_i      (mna_w),
        .nneg_i    (nnega_w),
        .side_i    (sidea_w),
        .out_valid (vb_w),
        .acc_o     (accb_w),
        .mn_o      (mnb_w),
        .nneg_o    (nnegb_w),
        .side_o    (sideb_w)
    );

    // Final stage: integer kelvin, clamp and status. This is the output register.
    logic [40:0] acc_mag;
    logic [24:0] kelvin;
    out_beat_t   out_next;
    logic        v_out_reg;

    always_comb begin
        acc_mag  = accb_w[AccW-1] ? 41'(-accb_w) : 41'(accb_w);
        kelvin   = acc_mag[40:16];
        out_next = '0;
        out_next.illuminance = sideb_w.lux;
        out_next.lux_clamped = sideb_w.luxc;
        out_next.cct_status  = StOk;
        if (sideb_w.zero) begin
            out_next.cct_status = StZero;
        end else if (sideb_w.dz) begin
            out_next.cct_status = StDenZero;
        end else if (accb_w[AccW-1] && kelvin != '0) begin
            out_next.cct_status = StClamp;
        end else if (kelvin > 25'(16'hFFFF)) begin
            out_next.temperature_kelvin = 16'hFFFF;
            out_next.cct_status         = StClamp;
        end else begin
            out_next.temperature_kelvin = kelvin[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_out_reg <= 1'b0;
        end else if (en) begin
            v_out_reg <= vb_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data <= out_next;
        end
    end

    assign out_valid = v_out_reg;

endmodule

// ===== rtl/ctlx_chk.sv =====
module ctlx_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input ctlx_pkg::in_beat_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input ctlx_pkg::out_beat_t m_data
);
    import ctlx_pkg::*;

    // The pipeline is empty right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result beat changed");

    // With no result waiting the block must take input.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output is empty");

    a_no_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.cct_status == StZero || m_data.cct_status == StDenZero)
        |-> m_data.temperature_kelvin == 16'd0)
        else $error("temperature given without a valid n");

    a_lux_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.lux_clamped
        |-> m_data.illuminance == 16'd0 || m_data.illuminance == 16'hFFFF)
        else $error("lux flagged clamped at an interior value");

endmodule

bind rgb_color_temperature_and_lux ctlx_chk u_chk (.*);

// ===== bench/tb_rgb_color_temperature_and_lux.sv =====
`timescale 1ns / 100ps

module tb_rgb_color_temperature_and_lux;
    import ctlx_pkg::*;

    localparam int FracBits  = 16;
    localparam int Latency   = 46;
    localparam int IdleLimit = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned idle_cycles = 0;
    bit          failed = 1'b0;
    out_beat_t   expected_beats[$];

    rgb_color_temperature_and_lux #(.COEFF_FRAC_BITS(FracBits)) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Coefficient m / 100000 rounded half away from zero (all m are positive).
    function automatic longint coeff(input longint m);
        return ((m <<< FracBits) + 50000) / 100000;
    endfunction

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // Scale by a non-negative Q.F coefficient, truncated toward zero.
    function automatic longint scale_q(input longint c, input longint v);
        longint m;
        longint r;
        m = absval(v);
        r = c * (m >>> FracBits) + ((c * (m & ((64'sd1 <<< FracBits) - 1))) >>> FracBits);
        return v < 0 ? -r : r;
    endfunction

    function automatic longint horner_step(input longint acc, input longint n,
                                           input longint k);
        longint bound;
        longint ma;
        longint mn;
        longint p;
        longint r;
        bound = 64'sd1 <<< 40;
        ma = absval(acc);
        mn = absval(n);
        if (mn != 0 && ma > (bound <<< 16) / mn) begin
            p = bound;
        end else begin
            p = (ma * mn) >>> 16;
            if (p > bound) p = bound;
        end
        r = (((acc < 0) != (n < 0)) ? -p : p) + k;
        if (r > bound) r = bound;
        if (r < -bound) r = -bound;
        return r;
    endfunction

    function automatic out_beat_t predict_cct_lux(input in_beat_t b);
        out_beat_t o;
        longint r, g, bl, x, y, z, s, num, den, q, n, acc, ycnt;
        r = longint'(b.red);
        g = longint'(b.green);
        bl = longint'(b.blue);
        x = -coeff(14282) * r + coeff(154924) * g - coeff(95641) * bl;
        y = -coeff(32466) * r + coeff(157837) * g - coeff(73191) * bl;
        z = -coeff(68202) * r + coeff(77073) * g + coeff(56332) * bl;
        o = '0;
        ycnt = absval(y) >>> FracBits;
        if (y < 0) ycnt = -ycnt;
        if (ycnt < 0) begin
            o.lux_clamped = 1'b1;
        end else if (ycnt > 65535) begin
            o.illuminance = 16'hFFFF;
            o.lux_clamped = 1'b1;
        end else begin
            o.illuminance = ycnt[15:0];
        end
        if (r == 0 && g == 0 && bl == 0) begin
            o.cct_status = StZero;
        end else begin
            s = x + y + z;
            num = x - scale_q(coeff(33200), s);
            den = scale_q(coeff(18580), s) - y;
            if (den == 0) begin
                o.cct_status = StDenZero;
            end else begin
                q = (absval(num) <<< 16) / absval(den);
                if ((num < 0) != (den < 0)) begin
                    if (q > 64'sd2147483648) q = 64'sd2147483648;
                    n = -q;
                end else begin
                    if (q > 64'sd2147483647) q = 64'sd2147483647;
                    n = q;
                end
                acc = 64'sd449 * 65536;
                acc = horner_step(acc, n, 64'sd3525 * 65536);
                acc = horner_step(acc, n, 64'sd447171789);
                acc = horner_step(acc, n, 64'sd361780347);
                q = absval(acc) >>> 16;
                acc = acc < 0 ? -q : q;
                if (acc < 0) begin
                    o.cct_status = StClamp;
                end else if (acc > 65535) begin
                    o.temperature_kelvin = 16'hFFFF;
                    o.cct_status = StClamp;
                end else begin
                    o.temperature_kelvin = acc[15:0];
                    o.cct_status = StOk;
                end
            end
        end
        return o;
    endfunction

    // Valid drops only while the sender idles, so back-to-back beats keep it high.
    task automatic send_sample(input logic [15:0] red, input logic [15:0] green,
                               input logic [15:0] blue);
        in_beat_t b;
        b = '{red: red, green: green, blue: blue};
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        expected_beats.push_back(predict_cct_lux(b));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drain();
        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (Latency + 4) @(posedge aclk);
    endtask

    // Receiver stall pattern; a fresh draw every cycle.
    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        out_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_data);
                failed = 1'b1;
            end else begin
                exp_beat = expected_beats.pop_front();
                if (m_data.temperature_kelvin !== exp_beat.temperature_kelvin ||
                    m_data.illuminance !== exp_beat.illuminance ||
                    m_data.cct_status !== exp_beat.cct_status ||
                    m_data.lux_clamped !== exp_beat.lux_clamped) begin
                    $display("%0t: mismatch expected kelvin %0d lux %0d status %0d luxc %0d",
                             $time, exp_beat.temperature_kelvin, exp_beat.illuminance,
                             exp_beat.cct_status, exp_beat.lux_clamped);
                    $display("%0t:          actual   kelvin %0d lux %0d status %0d luxc %0d",
                             $time, m_data.temperature_kelvin, m_data.illuminance,
                             m_data.cct_status, m_data.lux_clamped);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IdleLimit) begin
                $display("rgb_color_temperature_and_lux verification failed");
                $finish;
            end
        end
    end

    task automatic test_extremes();
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'd0, 16'd0);
        send_sample(16'd0, 16'hFFFF, 16'd0);
        send_sample(16'd0, 16'd0, 16'hFFFF);
        send_sample(16'd1, 16'd0, 16'd0);
        send_sample(16'd0, 16'd1, 16'd0);
        send_sample(16'd0, 16'd0, 16'd1);
        send_sample(16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'd0, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'd0, 16'hFFFF);
        send_sample(16'd1000, 16'd1000, 16'd1000);
        send_sample(16'd3000, 16'd2000, 16'd1000);
        send_sample(16'd1000, 16'd2000, 16'd3000);
        send_sample(16'd1, 16'd1, 16'd1);
        send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    endtask

    // Plausible sensor readings, where green dominates, keep n in range;
    // the rest spreads over the whole input space for clamps and saturation.
    task automatic test_random(input int count);
        logic [15:0] g;
        repeat (count) begin
            if ($urandom_range(3) != 0) begin
                g = 16'($urandom_range(65535));
                send_sample(16'($urandom_range(g)), g, 16'($urandom_range(g)));
            end else begin
                send_sample(16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 20;
        recv_idle_pct = 79;
        test_extremes();
        test_random(500);
        send_idle_pct = 79;
        recv_idle_pct = 20;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(500);
        s_valid <= 1'b0;
        wait_drain();
        if (!failed) begin
            $display("rgb_color_temperature_and_lux verification clean");
        end else begin
            $display("rgb_color_temperature_and_lux verification failed");
        end
        $finish;
    end

endmodule
